// ===== hdl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, codes and the control store of the console sequencer.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_IDX_W = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int LOC_OUT_W  = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_PUT,
    OP_SCR_INIT,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_FILL,
    OP_CLR_INIT,
    OP_RD_ISSUE,
    OP_RD_CAP,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_ACT_CLEAR,
    C_ACT_READ,
    C_ACT_OTHER,
    C_NO_SCROLL,
    C_COPY_MORE,
    C_FILL_MORE,
    C_OUT_BLOCKED
  } cond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_DEC_CLR  = 4'd1;
  localparam logic [PC_W-1:0] S_DEC_RD   = 4'd2;
  localparam logic [PC_W-1:0] S_DEC_PUT  = 4'd3;
  localparam logic [PC_W-1:0] S_PUT      = 4'd4;
  localparam logic [PC_W-1:0] S_SCR_INIT = 4'd5;
  localparam logic [PC_W-1:0] S_SCR_RD   = 4'd6;
  localparam logic [PC_W-1:0] S_SCR_WR   = 4'd7;
  localparam logic [PC_W-1:0] S_FILL     = 4'd8;
  localparam logic [PC_W-1:0] S_DONE     = 4'd9;
  localparam logic [PC_W-1:0] S_RET      = 4'd10;
  localparam logic [PC_W-1:0] S_CLR_INIT = 4'd11;
  localparam logic [PC_W-1:0] S_RD       = 4'd12;
  localparam logic [PC_W-1:0] S_RD_CAP   = 4'd13;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic act_clear;
    logic act_read;
    logic act_other;
    logic no_scroll;
    logic copy_more;
    logic fill_more;
    logic out_blocked;
  } status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_IDLE:     w = '{op: OP_WAIT,     cond: C_NO_ACCEPT,   target: S_IDLE};
      S_DEC_CLR:  w = '{op: OP_NOP,      cond: C_ACT_CLEAR,   target: S_CLR_INIT};
      S_DEC_RD:   w = '{op: OP_NOP,      cond: C_ACT_READ,    target: S_RD};
      S_DEC_PUT:  w = '{op: OP_NOP,      cond: C_ACT_OTHER,   target: S_DONE};
      S_PUT:      w = '{op: OP_PUT,      cond: C_NO_SCROLL,   target: S_DONE};
      S_SCR_INIT: w = '{op: OP_SCR_INIT, cond: C_NEVER,       target: S_IDLE};
      S_SCR_RD:   w = '{op: OP_COPY_RD,  cond: C_NEVER,       target: S_IDLE};
      S_SCR_WR:   w = '{op: OP_COPY_WR,  cond: C_COPY_MORE,   target: S_SCR_RD};
      S_FILL:     w = '{op: OP_FILL,     cond: C_FILL_MORE,   target: S_FILL};
      S_DONE:     w = '{op: OP_EMIT,     cond: C_OUT_BLOCKED, target: S_DONE};
      S_RET:      w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_IDLE};
      S_CLR_INIT: w = '{op: OP_CLR_INIT, cond: C_ALWAYS,      target: S_FILL};
      S_RD:       w = '{op: OP_RD_ISSUE, cond: C_NEVER,       target: S_IDLE};
      S_RD_CAP:   w = '{op: OP_RD_CAP,   cond: C_ALWAYS,      target: S_DONE};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/text_console_cursor_engine_core.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character cell console with cursor, wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                          Contents
// in       slave      in_tvalid/in_tready/in_tdata   action, char_code, cell_index
// out      master     out_tvalid/out_tready/out_tdata cursor, location, cell, scroll
// cfg      slave      cfg_valid/cfg_ready/cfg_data   text attribute
//
// A put without scroll or a read runs through the decode steps, then the put
// or the read issue and capture, then the emit and return steps.
// A scroll adds a row copy, one memory port access per cycle, and then the
// bottom row blanking.
// A clear blanks every cell; after reset a blanking pass over all cells
// runs before the first transaction is accepted.
// A stalled result holds the next transaction at its emit step until it is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // action[1:0], char_code[9:2], cell_index[20:10]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cursor_row[4:0], cursor_col[11:5], cursor_location[22:12],
  // read_data[38:23], scrolled[39]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tcce_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcce_pkg::ATTR_W-1:0]       cfg_data
);
  import tcce_pkg::*;

  op_t     op;
  status_t status;

  tcce_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  tcce_datapath #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .status     (status),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

endmodule

// ===== hdl/tcce_sequencer.sv =====
// ----------------------------------------------------------------------------
// Console sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module tcce_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  tcce_pkg::status_t status,
  output tcce_pkg::op_t     op
);
  import tcce_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          word;
  logic            take;

  assign word = ucode(pc_r);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_ACCEPT:   take = !status.accept;
      C_ACT_CLEAR:   take = status.act_clear;
      C_ACT_READ:    take = status.act_read;
      C_ACT_OTHER:   take = status.act_other;
      C_NO_SCROLL:   take = status.no_scroll;
      C_COPY_MORE:   take = status.copy_more;
      C_FILL_MORE:   take = status.fill_more;
      C_OUT_BLOCKED: take = status.out_blocked;
      default:       take = 1'b0;
    endcase
    pc_nxt = take ? word.target : pc_r + 1'b1;
  end

  // After reset the sequencer starts in the fill loop to blank the buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_FILL;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/tcce_datapath.sv =====
// ----------------------------------------------------------------------------
// Console datapath
// Cell buffer, cursor, address counter, attribute and result registers.
// ----------------------------------------------------------------------------
module tcce_datapath #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tcce_pkg::op_t                        op,
  output tcce_pkg::status_t                    status,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tcce_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcce_pkg::ATTR_W-1:0]          cfg_data
);
  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int RXW   = $clog2(ROWS + 1);
  localparam int CXW   = $clog2(COLS + TAB_WIDTH);
  localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] FILL_LAST = AW'(CELLS - 1);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  logic [ACTION_W-1:0]   action_r;
  logic [CHAR_W-1:0]     char_r;
  logic [CELL_IDX_W-1:0] cell_r;
  logic [ATTR_W-1:0]     attr_r;
  logic [RW-1:0]         row_r;
  logic [CW-1:0]         col_r;
  logic [AW-1:0]         addr_r;
  logic                  item_r;
  logic                  scrolled_r;
  logic [CELL_W-1:0]     data_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CXW-1:0] tab_stop [COLS];
  logic [CXW-1:0] col_x;
  logic [RXW-1:0] row_x;
  logic [CW-1:0]  col_fin;
  logic [RW-1:0]  row_fin;
  logic           printable;
  logic           scroll;
  logic [AW-1:0]  loc;
  logic           cell_ok;
  logic           accept;
  logic           out_free;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  for (genvar g = 0; g < COLS; g++) begin : g_tab
    assign tab_stop[g] = CXW'((g / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  assign in_tready  = (op == OP_WAIT);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign loc       = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign cell_ok   = (32'(cell_r) < 32'(CELLS));
  assign printable = !char_r[CHAR_W-1] && (char_r >= CH_SPACE);

  always_comb begin
    col_x = CXW'(col_r);
    row_x = RXW'(row_r);
    case (char_r)
      CH_BS: begin
        if (col_r != '0) begin
          col_x = CXW'(col_r) - 1'b1;
        end
      end
      CH_TAB: col_x = tab_stop[col_r];
      CH_CR:  col_x = '0;
      CH_LF: begin
        col_x = '0;
        row_x = RXW'(row_r) + 1'b1;
      end
      default: begin
        if (printable) begin
          col_x = CXW'(col_r) + 1'b1;
        end
      end
    endcase
    if (32'(col_x) >= 32'(COLS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    col_fin = CW'(col_x);
    scroll  = (32'(row_x) >= 32'(ROWS));
    row_fin = scroll ? RW'(ROWS - 1) : RW'(row_x);
  end

  assign status = '{
    accept:      accept,
    act_clear:   (action_r == ACT_CLEAR),
    act_read:    (action_r == ACT_READ),
    act_other:   (action_r != ACT_PUT),
    no_scroll:   !scroll,
    copy_more:   (addr_r != COPY_LAST),
    fill_more:   (addr_r != FILL_LAST),
    out_blocked: !out_free
  };

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = BLANK_CELL;
    raddr = AW'(cell_r);
    case (op)
      OP_PUT: begin
        we    = printable;
        waddr = loc;
        wdata = {attr_r, char_r};
      end
      OP_COPY_RD: raddr = addr_r + AW'(COLS);
      OP_COPY_WR: begin
        we    = 1'b1;
        wdata = rdata_r;
      end
      OP_FILL: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_tdata[ACTION_W-1:0];
      char_r   <= in_tdata[ACTION_W +: CHAR_W];
      cell_r   <= in_tdata[ACTION_W+CHAR_W +: CELL_IDX_W];
    end
    if (op == OP_EMIT && item_r && out_free) begin
      out_data_r <= {scrolled_r, data_r, LOC_OUT_W'(loc), COL_OUT_W'(col_r),
                     ROW_OUT_W'(row_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      addr_r      <= '0;
      item_r      <= 1'b0;
      scrolled_r  <= 1'b0;
      data_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      if (accept) begin
        item_r     <= 1'b1;
        scrolled_r <= 1'b0;
        data_r     <= '0;
      end
      case (op)
        OP_PUT: begin
          row_r      <= row_fin;
          col_r      <= col_fin;
          scrolled_r <= scroll;
        end
        OP_SCR_INIT: addr_r <= '0;
        OP_COPY_WR:  addr_r <= addr_r + 1'b1;
        OP_FILL:     addr_r <= addr_r + 1'b1;
        OP_CLR_INIT: begin
          addr_r <= '0;
          row_r  <= '0;
          col_r  <= '0;
        end
        OP_RD_CAP: data_r <= cell_ok ? rdata_r : '0;
        default: addr_r <= addr_r;
      endcase
      if (op == OP_EMIT && item_r && out_free) begin
        item_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// Console port checker
// Assertions on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module tcce_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tcce_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tcce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a transaction is in progress.");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> out_tdata[4:0] == 5'(ROWS - 1))
    else $error("Scroll reported with the cursor off the last row.");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[11:5]} < 8'(COLS))
    else $error("Cursor column out of range.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("Ports active right after reset.");

endmodule

bind text_console_cursor_engine_core tcce_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcce_checker (.*);

// ===== dv/text_console_cursor_engine_checker.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine checker
// Watches the input, result and attribute channels of the console engine.
// It keeps its own cell buffer, cursor and attribute, works out the result
// of every accepted transaction and compares each returned result with the
// oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_checker #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tcce_pkg::ATTR_W-1:0]      cfg_data,
  output int                               fail_count,
  output int                               pending_count,
  output int                               result_count,
  output int                               read_count,
  output int                               clear_count,
  output int                               scroll_count,
  output int                               attr_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLS;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [LOC_OUT_W-1:0] loc;
    logic [CELL_W-1:0]    data;
    logic                 scrolled;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] attr;
  console_result_t   cursor_results_q[$];
  int                errors;
  int                n_results;
  int                n_reads;
  int                n_clears;
  int                n_scrolls;
  int                n_attr;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] mismatch in %s on result %0d: got 0x%0h, expected 0x%0h",
               $time, what, n_results, got, want);
    end
  endtask

  function automatic console_result_t console_step(input logic [ACTION_W-1:0] act,
                                                   input logic [CHAR_W-1:0]   code,
                                                   input logic [CELL_IDX_W-1:0] cell_idx);
    console_result_t r;
    int              row;
    int              col;
    int              i;
    r   = '0;
    row = cur_row;
    col = cur_col;
    if (act == ACT_PUT) begin
      case (code)
        CH_BS: begin
          if (col != 0) col--;
        end
        CH_TAB: col = (col + TAB_WIDTH) - ((col + TAB_WIDTH) % TAB_WIDTH);
        CH_CR: col = 0;
        CH_LF: begin
          col = 0;
          row++;
        end
        default: begin
          if (code >= CH_SPACE && !code[CHAR_W-1]) begin
            screen[row * COLS + col] = {attr, code};
            col++;
          end
        end
      endcase
      if (col >= COLS) begin
        col = 0;
        row++;
      end
      if (row >= ROWS) begin
        for (i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
        for (i = (ROWS - 1) * COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
        row        = ROWS - 1;
        r.scrolled = 1'b1;
      end
      cur_row = row;
      cur_col = col;
    end else if (act == ACT_CLEAR) begin
      foreach (screen[k]) screen[k] = BLANK_CELL;
      cur_row = 0;
      cur_col = 0;
    end else if (act == ACT_READ) begin
      if (cell_idx < CELLS) r.data = screen[cell_idx];
    end
    r.row = ROW_OUT_W'(cur_row);
    r.col = COL_OUT_W'(cur_col);
    r.loc = LOC_OUT_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (!rst_n) begin
      foreach (screen[k]) screen[k] = BLANK_CELL;
      cur_row = 0;
      cur_col = 0;
      attr    = ATTR_RESET;
      cursor_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.row      = out_tdata[4:0];
        got.col      = out_tdata[11:5];
        got.loc      = out_tdata[22:12];
        got.data     = out_tdata[38:23];
        got.scrolled = out_tdata[39];
        n_results++;
        if (cursor_results_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding", out_tdata, 0);
        end else begin
          want = cursor_results_q.pop_front();
          if (got.row !== want.row) report_mismatch("cursor_row", got.row, want.row);
          if (got.col !== want.col) report_mismatch("cursor_col", got.col, want.col);
          if (got.loc !== want.loc) report_mismatch("cursor_location", got.loc, want.loc);
          if (got.data !== want.data) report_mismatch("read_data", got.data, want.data);
          if (got.scrolled !== want.scrolled) begin
            report_mismatch("scrolled", got.scrolled, want.scrolled);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        attr = cfg_data;
        n_attr++;
      end
      if (in_tvalid && in_tready) begin
        want = console_step(in_tdata[1:0], in_tdata[9:2], in_tdata[20:10]);
        cursor_results_q.push_back(want);
        if (in_tdata[1:0] == ACT_READ) n_reads++;
        if (in_tdata[1:0] == ACT_CLEAR) n_clears++;
        if (want.scrolled) n_scrolls++;
      end
    end
    fail_count    <= errors;
    pending_count <= cursor_results_q.size();
    result_count  <= n_results;
    read_count    <= n_reads;
    clear_count   <= n_clears;
    scroll_count  <= n_scrolls;
    attr_count    <= n_attr;
  end

endmodule

// ===== dv/tb_text_console_cursor_engine_core.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives put, clear, read and unused actions into the console engine with
// random source gaps and sink stalls, across several text attribute settings.
// A directed opening covers field extremes and the control codes; random
// bursts of text, line feeds, tabs, cell sweeps and noise then drive the
// cursor through wrap and scroll. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int ROWS        = 25;
  localparam int COLS        = 80;
  localparam int TAB_WIDTH   = 8;
  localparam int CELLS       = ROWS * COLS;
  localparam int ITEM_TARGET = 1050;
  localparam int PHASES      = 6;
  localparam int QUIET_LIMIT = 20000;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [ATTR_W-1:0]      cfg_data   = '0;

  int fail_count;
  int pending_count;
  int result_count;
  int read_count;
  int clear_count;
  int scroll_count;
  int attr_count;

  int items_sent     = 0;
  int sender_run     = 0;
  bit sender_quiet   = 1'b0;
  int receiver_run   = 0;
  bit receiver_quiet = 1'b0;
  int quiet_cycles   = 0;

  always #1 clk = ~clk;

  text_console_cursor_engine_core #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  text_console_cursor_engine_checker #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .read_count    (read_count),
    .clear_count   (clear_count),
    .scroll_count  (scroll_count),
    .attr_count    (attr_count)
  );

  task automatic send_item(input logic [ACTION_W-1:0]   act,
                           input logic [CHAR_W-1:0]     code,
                           input logic [CELL_IDX_W-1:0] cell_idx);
    int gap;
    if (sender_run == 0) begin
      sender_run   = $urandom_range(8, 48);
      sender_quiet = ($urandom_range(0, 3) == 0);
    end
    sender_run--;
    gap = sender_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({cell_idx, code, act});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_byte(input logic [CHAR_W-1:0] code);
    send_item(ACT_PUT, code, CELL_IDX_W'($urandom));
  endtask

  task automatic read_cell(input int cell_idx);
    send_item(ACT_READ, CHAR_W'($urandom), CELL_IDX_W'(cell_idx));
  endtask

  task automatic clear_screen();
    send_item(ACT_CLEAR, CHAR_W'($urandom), CELL_IDX_W'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] any_printable();
    return CHAR_W'($urandom_range(32'(CH_SPACE), 127));
  endfunction

  function automatic logic [CHAR_W-1:0] any_control();
    logic [CHAR_W-1:0] code;
    case ($urandom_range(0, 3))
      0:       code = CH_BS;
      1:       code = CH_TAB;
      2:       code = CH_CR;
      default: code = CH_LF;
    endcase
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] any_ignored();
    logic [CHAR_W-1:0] code;
    code = CHAR_W'($urandom_range(128, 255));
    if ($urandom_range(0, 1) == 0) begin
      code = CHAR_W'($urandom_range(0, 31));
      if (code == CH_BS || code == CH_TAB || code == CH_CR || code == CH_LF) code = '0;
    end
    return code;
  endfunction

  task automatic run_burst();
    int kind;
    int len;
    int i;
    int r;
    int base;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(10, 60);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 72) put_byte(any_printable());
        else if (r < 82) put_byte(any_control());
        else if (r < 86) put_byte(CHAR_W'($urandom));
        else if (r < 94) read_cell($urandom_range((ROWS - 3) * COLS, CELLS - 1));
        else read_cell($urandom_range(0, 2047));
      end
    end else if (kind < 56) begin
      len = $urandom_range(1, 16);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) put_byte(any_printable());
        else put_byte(CH_LF);
      end
      read_cell($urandom_range((ROWS - 2) * COLS, CELLS - 1));
    end else if (kind < 64) begin
      len = $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 2) == 0) put_byte(any_printable());
        put_byte(CH_TAB);
      end
    end else if (kind < 79) begin
      if ($urandom_range(0, 3) == 0) base = $urandom_range(0, ROWS - 1) * COLS;
      else base = $urandom_range(ROWS - 4, ROWS - 1) * COLS;
      base = base + $urandom_range(0, COLS - 1);
      len  = $urandom_range(8, 40);
      for (i = 0; i < len; i++) read_cell(base + i);
    end else if (kind < 87) begin
      len = $urandom_range(2, 8);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 2);
        if (r == 0) send_item(ACT_UNUSED, CHAR_W'($urandom), CELL_IDX_W'($urandom));
        else if (r == 1) put_byte(any_ignored());
        else read_cell($urandom_range(CELLS, 2047));
      end
    end else if (kind < 90) begin
      clear_screen();
      read_cell($urandom_range(0, CELLS - 1));
    end else begin
      len = $urandom_range(2, 12);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 5);
        if (r < 3) put_byte(CH_BS);
        else if (r == 3) put_byte(CH_CR);
        else put_byte(any_printable());
      end
    end
    if ($urandom_range(0, 19) == 0) drain_results();
  endtask

  initial begin
    int stall;
    forever begin
      if (receiver_run == 0) begin
        receiver_run   = $urandom_range(8, 48);
        receiver_quiet = ($urandom_range(0, 3) == 0);
      end
      receiver_run--;
      stall = receiver_quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No transaction for %0d cycles, %0d results outstanding.",
               quiet_cycles, pending_count);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                p;
    int                quota;
    logic [ATTR_W-1:0] attr_value;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Opening sequence at the reset attribute.
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(2047);
    read_cell(CELLS);
    put_byte(8'h41);
    put_byte(8'h7F);
    put_byte(CH_SPACE);
    put_byte(8'h1F);
    put_byte(8'h00);
    put_byte(8'h80);
    put_byte(8'hFF);
    repeat (4) put_byte(CH_BS);
    put_byte(CH_TAB);
    put_byte(CH_CR);
    put_byte(CH_LF);
    send_item(ACT_UNUSED, 8'hFF, 11'h7FF);
    read_cell(0);
    read_cell(1);
    clear_screen();
    read_cell(0);
    read_cell(2);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       attr_value = 8'hFF;
        1:       attr_value = 8'h00;
        PHASES - 1: attr_value = ATTR_RESET;
        default: attr_value = ATTR_W'($urandom);
      endcase
      write_attr(attr_value);
      quota = (p + 1) * ITEM_TARGET / PHASES;
      while (items_sent < quota) run_burst();
    end

    drain_results();
    repeat (16) @(posedge clk);
    $display("Checked %0d results from %0d transactions: %0d cell reads, %0d clears, %0d scrolls.",
             result_count, items_sent, read_count, clear_count, scroll_count);
    $display("Text attribute written %0d times, including all-zero and all-one values.",
             attr_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== text_console_cursor_engine_core.f =====
hdl/tcce_pkg.sv
hdl/tcce_sequencer.sv
hdl/tcce_datapath.sv
hdl/text_console_cursor_engine_core.sv
hdl/tcce_checker.sv
dv/text_console_cursor_engine_checker.sv
dv/tb_text_console_cursor_engine_core.sv
